// File: sv/edf_ready_queue_core_assert.svh
// Assertion macros shared by the ready queue RTL.
`ifndef EDF_READY_QUEUE_CORE_ASSERT_SVH
`define EDF_READY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define EDFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define EDFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/edfq_pkg.sv
// Package with the request and response types and the codes of the ready queue.
package edfq_pkg;

    // Request codes.
    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_ENQUEUE  = 3'd1;
    localparam logic [2:0] REQ_DEQUEUE  = 3'd2;
    localparam logic [2:0] REQ_PICK     = 3'd3;
    localparam logic [2:0] REQ_CHECK    = 3'd4;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_EMPTY   = 2'd3;

    localparam int TASK_W     = 16;
    localparam int DEADLINE_W = 64;
    localparam int COUNT_W    = 5;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [TASK_W-1:0]     task_id;
        logic [DEADLINE_W-1:0] deadline;
        logic                  task_exiting;
        logic [TASK_W-1:0]     current_id;
    } edfq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TASK_W-1:0]  chosen_id;
        logic               resched;
        logic [COUNT_W-1:0] ready_count;
    } edfq_resp_t;

endpackage

// File: sv/edfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module edfq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/edf_ready_queue_core.sv
// Earliest-deadline-first ready table: scan sequencer, slot state and response register.
//
// Usage: one request enters on the s_ channel (s_valid/s_ready, payload s_req) and
// exactly one response leaves on the m_ channel (m_valid/m_ready, payload m_resp).
// A request registers a task, enqueues it with a deadline, dequeues it, picks the
// ready task with the earliest deadline, or checks whether that task should preempt
// the running one.
// Each request runs a scan over every slot, then a drain step and a finish step that
// forms the response. The scan sets the pace: task ids and deadlines sit in two RAMs
// with a single read port, one slot is read per cycle, and a single 64-bit comparator
// tracks the minimum deadline and then settles the preemption compare.
// s_ready is high only while the sequencer is idle. A finished response waits in an
// output register, so the next request is accepted while the receiver stalls; it then
// holds in its last step until the output register is free.
// Reset clears every slot's used and ready bit and the ready count; the RAM contents
// stay undefined and are only evaluated for slots in use, so no clearing pass is needed.
`include "edf_ready_queue_core_assert.svh"

module edf_ready_queue_core #(
    parameter int SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  edfq_pkg::edfq_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output edfq_pkg::edfq_resp_t m_resp
);

    import edfq_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SAT_W = CNT_W + COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [SAT_W-1:0] SAT_MAX  = SAT_W'((1 << COUNT_W) - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    edfq_req_t              req_reg, req_next;
    logic [SLOTS-1:0]       used_reg, used_next;
    logic [SLOTS-1:0]       ready_reg, ready_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]       proc_idx_reg, proc_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   best_found_reg, best_found_next;
    logic [DEADLINE_W-1:0]  best_dl_reg, best_dl_next;
    logic [TASK_W-1:0]      best_task_reg, best_task_next;
    logic                   cur_found_reg, cur_found_next;
    logic [DEADLINE_W-1:0]  cur_dl_reg, cur_dl_next;
    logic                   m_valid_reg, m_valid_next;
    edfq_resp_t             resp_reg, resp_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [TASK_W-1:0]      wr_task;
    logic [DEADLINE_W-1:0]  wr_dl;
    logic [TASK_W-1:0]      rd_task;
    logic [DEADLINE_W-1:0]  rd_dl;

    logic [DEADLINE_W-1:0]  cmp_a;
    logic [DEADLINE_W-1:0]  cmp_b;
    logic                   cmp_lt;

    // Task id and deadline stores, read one slot per scan cycle.
    edfq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (SLOTS)
    ) u_task_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_task),
        .rd_addr (idx_reg),
        .rd_data (rd_task)
    );

    edfq_ram #(
        .WIDTH (DEADLINE_W),
        .DEPTH (SLOTS)
    ) u_deadline_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_dl),
        .rd_addr (idx_reg),
        .rd_data (rd_dl)
    );

    // Shared comparator: minimum search during the scan, preemption test at the end.
    always_comb begin
        if (state_reg == S_FINISH) begin
            cmp_a = best_dl_reg;
            cmp_b = cur_dl_reg;
        end else begin
            cmp_a = rd_dl;
            cmp_b = best_dl_reg;
        end
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // Sequencer, slot updates and response formation.
    always_comb begin
        logic [SAT_W-1:0] total_wide;

        state_next      = state_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        ready_next      = ready_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_dl_next    = best_dl_reg;
        best_task_next  = best_task_reg;
        cur_found_next  = cur_found_reg;
        cur_dl_next     = cur_dl_reg;
        m_valid_next    = m_valid_reg;
        resp_next       = resp_reg;
        wr_en           = 1'b0;
        wr_idx          = match_idx_reg;
        wr_task         = req_reg.task_id;
        wr_dl           = req_reg.deadline;
        total_wide      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_req;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    cur_found_next  = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                proc_valid_next = 1'b1;
                proc_idx_next   = idx_reg;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    resp_next.status    = STATUS_OK;
                    resp_next.chosen_id = '0;
                    resp_next.resched   = 1'b0;
                    case (req_reg.req_type)
                        REQ_REGISTER: begin
                            if (!found_reg) begin
                                if (!free_found_reg) begin
                                    resp_next.status = STATUS_FULL;
                                end else begin
                                    used_next[free_idx_reg]  = 1'b1;
                                    ready_next[free_idx_reg] = 1'b0;
                                    wr_en   = 1'b1;
                                    wr_idx  = free_idx_reg;
                                    wr_dl   = '0;
                                end
                            end
                        end
                        REQ_ENQUEUE: begin
                            if (!found_reg) begin
                                resp_next.status = STATUS_UNKNOWN;
                            end else begin
                                wr_en = 1'b1;
                                if (!ready_reg[match_idx_reg]) begin
                                    ready_next[match_idx_reg] = 1'b1;
                                    total_next = total_reg + 1'b1;
                                end
                            end
                        end
                        REQ_DEQUEUE: begin
                            if (!found_reg) begin
                                resp_next.status = STATUS_UNKNOWN;
                            end else begin
                                if (ready_reg[match_idx_reg]) begin
                                    ready_next[match_idx_reg] = 1'b0;
                                    if (total_reg != '0) begin
                                        total_next = total_reg - 1'b1;
                                    end
                                end
                                if (req_reg.task_exiting) begin
                                    used_next[match_idx_reg] = 1'b0;
                                end
                            end
                        end
                        REQ_PICK, REQ_CHECK: begin
                            if (!best_found_reg) begin
                                resp_next.status = STATUS_EMPTY;
                            end else begin
                                resp_next.chosen_id = best_task_reg;
                                if (req_reg.req_type == REQ_CHECK) begin
                                    if (!cur_found_reg) begin
                                        resp_next.status = STATUS_UNKNOWN;
                                    end else begin
                                        resp_next.resched = cmp_lt;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    // The reported count saturates at the field's maximum.
                    total_wide = SAT_W'(total_next);
                    if (total_wide > SAT_MAX) begin
                        total_wide = SAT_MAX;
                    end
                    resp_next.ready_count = total_wide[COUNT_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Evaluate the slot whose RAM data arrives this cycle.
        if (proc_valid_reg && used_reg[proc_idx_reg]) begin
            if (!found_reg && rd_task == req_reg.task_id) begin
                found_next     = 1'b1;
                match_idx_next = proc_idx_reg;
            end
            if (!cur_found_reg && rd_task == req_reg.current_id) begin
                cur_found_next = 1'b1;
                cur_dl_next    = rd_dl;
            end
            if (ready_reg[proc_idx_reg] && (!best_found_reg || cmp_lt)) begin
                best_found_next = 1'b1;
                best_dl_next    = rd_dl;
                best_task_next  = rd_task;
            end
        end else if (proc_valid_reg && !free_found_reg) begin
            free_found_next = 1'b1;
            free_idx_next   = proc_idx_reg;
        end
    end

    // State, slot bits and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            ready_reg      <= '0;
            total_reg      <= '0;
            proc_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            ready_reg      <= ready_next;
            total_reg      <= total_next;
            proc_valid_reg <= proc_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        proc_idx_reg   <= proc_idx_next;
        found_reg      <= found_next;
        match_idx_reg  <= match_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_found_reg <= best_found_next;
        best_dl_reg    <= best_dl_next;
        best_task_reg  <= best_task_next;
        cur_found_reg  <= cur_found_next;
        cur_dl_reg     <= cur_dl_next;
        resp_reg       <= resp_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_resp  = resp_reg;

    // A slot is only ready while it is in use.
    `EDFQ_ASSERT_NOW(a_ready_in_use, 1'b1, ((ready_reg & ~used_reg) == '0),
        "ready bit set on a free slot")
    // The ready count tracks the ready bits.
    `EDFQ_ASSERT_NOW(a_count_match, 1'b1, (CNT_W'($countones(ready_reg)) == total_reg),
        "ready count differs from ready bits")
    // An accepted request starts the scan.
    `EDFQ_ASSERT_NEXT(a_accept_scan, (s_valid && s_ready), (state_reg == S_SCAN),
        "accepted request did not start the scan")
    // Slot evaluation only happens while the scan is running or draining.
    `EDFQ_ASSERT_NOW(a_proc_window, proc_valid_reg,
        ((state_reg == S_SCAN) || (state_reg == S_DRAIN)),
        "slot evaluated outside the scan")

endmodule

// File: tb/sv/edf_ready_queue_core_test.sv
// Self-checking testbench for the earliest-deadline-first ready queue core.
module edf_ready_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import edfq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int POOL_SIZE   = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SEGMENT_LEN = 50;
    localparam int SEGMENTS    = 9;

    // Request codes that the block does not decode.
    localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

    // Tracks the slot table the way the block should, and holds the responses still due.
    class ready_table_tracker;
        bit              used [SLOTS];
        bit              queued [SLOTS];
        logic [15:0]     owner [SLOTS];
        logic [63:0]     due_time [SLOTS];
        int unsigned     queued_total;
        edfq_resp_t      due_responses [$];
        int unsigned     mismatches;
        int unsigned     req_seen [8];
        int unsigned     status_seen [4];
        int unsigned     resched_seen;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                used[i]     = 1'b0;
                queued[i]   = 1'b0;
                owner[i]    = '0;
                due_time[i] = '0;
            end
            queued_total = 0;
            mismatches   = 0;
            resched_seen = 0;
            foreach (req_seen[i]) req_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Slot holding the given task, or -1 when the task is not registered.
        function int slot_of(logic [15:0] id);
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i] && owner[i] == id) return i;
            end
            return -1;
        endfunction

        // Applies an accepted request to the table and queues the response it must produce.
        function void note_request(edfq_req_t r);
            edfq_resp_t exp;
            int s;
            int e;
            int c;
            exp = '0;
            exp.status = STATUS_OK;
            case (r.req_type)
                REQ_REGISTER: begin
                    if (slot_of(r.task_id) < 0) begin
                        s = -1;
                        for (int i = 0; i < SLOTS && s < 0; i++) begin
                            if (!used[i]) s = i;
                        end
                        if (s < 0) begin
                            exp.status = STATUS_FULL;
                        end else begin
                            used[s]     = 1'b1;
                            queued[s]   = 1'b0;
                            owner[s]    = r.task_id;
                            due_time[s] = '0;
                        end
                    end
                end
                REQ_ENQUEUE: begin
                    s = slot_of(r.task_id);
                    if (s < 0) begin
                        exp.status = STATUS_UNKNOWN;
                    end else begin
                        due_time[s] = r.deadline;
                        if (!queued[s]) begin
                            queued[s] = 1'b1;
                            queued_total++;
                        end
                    end
                end
                REQ_DEQUEUE: begin
                    s = slot_of(r.task_id);
                    if (s < 0) begin
                        exp.status = STATUS_UNKNOWN;
                    end else begin
                        if (queued[s]) begin
                            queued[s] = 1'b0;
                            if (queued_total > 0) queued_total--;
                        end
                        if (r.task_exiting) used[s] = 1'b0;
                    end
                end
                REQ_PICK, REQ_CHECK: begin
                    // Earliest deadline among ready tasks; ties keep the lower slot.
                    e = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (used[i] && queued[i] &&
                            (e < 0 || due_time[i] < due_time[e])) e = i;
                    end
                    if (e < 0) begin
                        exp.status = STATUS_EMPTY;
                    end else begin
                        exp.chosen_id = owner[e];
                        if (r.req_type == REQ_CHECK) begin
                            c = slot_of(r.current_id);
                            if (c < 0) exp.status = STATUS_UNKNOWN;
                            else if (due_time[e] < due_time[c]) exp.resched = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            exp.ready_count = (queued_total > 31) ? 5'd31 : 5'(queued_total);
            req_seen[r.req_type]++;
            due_responses.push_back(exp);
        endfunction

        // Compares one accepted response with the oldest one still due.
        function void check_response(edfq_resp_t got);
            edfq_resp_t exp;
            bit bad;
            if (due_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: response with nothing due: ",
                              "status %0d id %h resched %0d count %0d"},
                             got.status, got.chosen_id, got.resched, got.ready_count);
                return;
            end
            exp = due_responses.pop_front();
            status_seen[got.status]++;
            if (got.resched === 1'b1) resched_seen++;
            bad = (got.status !== exp.status) || (got.chosen_id !== exp.chosen_id) ||
                  (got.resched !== exp.resched) || (got.ready_count !== exp.ready_count);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch at %0t: expected status %0d id %h resched %0d ",
                              "count %0d, got status %0d id %h resched %0d count %0d"},
                             $realtime, exp.status, exp.chosen_id, exp.resched,
                             exp.ready_count, got.status, got.chosen_id, got.resched,
                             got.ready_count);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    edfq_req_t  s_req   = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    edfq_resp_t m_resp;

    ready_table_tracker tracker = new();
    logic [15:0]        id_pool [POOL_SIZE];
    bit                 sender_calm = 1'b0;
    int unsigned        quiet_cycles = 0;

    edf_ready_queue_core #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_resp  (m_resp)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Ends the run when no request and no response has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic edfq_req_t compose(logic [2:0] kind, logic [15:0] id, logic [63:0] dl,
                                          logic exiting, logic [15:0] cur);
        edfq_req_t r;
        r.req_type     = kind;
        r.task_id      = id;
        r.deadline     = dl;
        r.task_exiting = exiting;
        r.current_id   = cur;
        return r;
    endfunction

    // Random request; the fill mix grows the table, the drain mix empties it.
    function automatic edfq_req_t make_request(bit fill);
        int          roll;
        int          dl_roll;
        logic [2:0]  kind;
        logic [15:0] id;
        logic [15:0] cur;
        logic [63:0] dl;
        logic        exiting;
        roll = $urandom_range(0, 99);
        if (fill) begin
            if (roll < 45)      kind = REQ_REGISTER;
            else if (roll < 70) kind = REQ_ENQUEUE;
            else if (roll < 78) kind = REQ_DEQUEUE;
            else if (roll < 88) kind = REQ_PICK;
            else if (roll < 97) kind = REQ_CHECK;
            else                kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        end else begin
            if (roll < 8)       kind = REQ_REGISTER;
            else if (roll < 28) kind = REQ_ENQUEUE;
            else if (roll < 65) kind = REQ_DEQUEUE;
            else if (roll < 78) kind = REQ_PICK;
            else if (roll < 97) kind = REQ_CHECK;
            else                kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        end
        id  = ($urandom_range(0, 99) < 92) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : 16'($urandom_range(0, 65535));
        cur = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : 16'($urandom_range(0, 65535));
        // Deadlines lean toward the extremes and small values so that ties happen.
        dl_roll = $urandom_range(0, 99);
        if (dl_roll < 15)      dl = '0;
        else if (dl_roll < 25) dl = '1;
        else if (dl_roll < 45) dl = 64'($urandom_range(0, 7));
        else                   dl = {$urandom, $urandom};
        if (kind == REQ_DEQUEUE) exiting = ($urandom_range(0, 99) < (fill ? 20 : 60));
        else                     exiting = 1'($urandom_range(0, 1));
        return compose(kind, id, dl, exiting, cur);
    endfunction

    // Offers one request after a random gap and waits for it to be taken.
    task automatic send_request(edfq_req_t r);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(r);
    endtask

    // Response side: random stalls, calm stretches, and one long hold-off.
    initial begin
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken == 120) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = calm ? 0 : $urandom_range(0, 7);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_response(m_resp);
            taken++;
            if (taken % 60 == 0) calm = ($urandom_range(0, 2) == 0);
        end
    end

    // Reset, directed requests, random requests, drain and verdict.
    initial begin
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom_range(0, 65535));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: nothing to pick, unknown ids.
        send_request(compose(REQ_PICK, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_CHECK, 16'hFFFF, '1, 1'b1, 16'hFFFF));
        send_request(compose(REQ_ENQUEUE, 16'h1234, 64'd5, 1'b0, 16'h0000));
        send_request(compose(REQ_DEQUEUE, 16'h1234, '0, 1'b1, 16'h0000));
        // Registration, a duplicate, and a pick while nothing is ready.
        send_request(compose(REQ_REGISTER, 16'h0000, '1, 1'b1, 16'hFFFF));
        send_request(compose(REQ_REGISTER, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_REGISTER, 16'hFFFF, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_PICK, 16'h0000, '0, 1'b0, 16'h0000));
        // Extreme deadlines, preemption with earlier, equal and unknown current task.
        send_request(compose(REQ_ENQUEUE, 16'h0000, '1, 1'b0, 16'h0000));
        send_request(compose(REQ_ENQUEUE, 16'hFFFF, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_PICK, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_CHECK, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_CHECK, 16'h0000, '0, 1'b0, 16'hFFFF));
        send_request(compose(REQ_CHECK, 16'h0000, '0, 1'b0, 16'h5A5A));
        // Re-enqueue of a ready task replaces its deadline; the tie goes to the lower slot.
        send_request(compose(REQ_ENQUEUE, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_PICK, 16'hFFFF, '1, 1'b1, 16'hFFFF));
        // Dequeue while ready, again while not ready with exit, and exit of a ready task.
        send_request(compose(REQ_DEQUEUE, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_DEQUEUE, 16'h0000, '0, 1'b1, 16'h0000));
        send_request(compose(REQ_DEQUEUE, 16'hFFFF, '0, 1'b1, 16'h0000));
        // Undecoded request codes change nothing.
        send_request(compose(REQ_SPARE_LO, 16'hFFFF, '1, 1'b1, 16'hFFFF));
        send_request(compose(REQ_SPARE_MID, 16'h0000, '0, 1'b0, 16'h0000));
        send_request(compose(REQ_SPARE_HI, 16'hA5A5, {$urandom, $urandom}, 1'b1, 16'h5A5A));
        // A freed slot is claimed again.
        send_request(compose(REQ_REGISTER, 16'h8001, '0, 1'b0, 16'h0000));

        // Random part in alternating fill and drain segments.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < SEGMENT_LEN; k++) send_request(make_request(seg % 2 == 0));
        end

        s_valid <= 1'b0;
        while (tracker.due_responses.size() != 0) @(posedge aclk);
        repeat (SLOTS + 8) @(posedge aclk);

        $display({"Requests: %0d register, %0d enqueue, %0d dequeue, %0d pick, ",
                  "%0d check, %0d undecoded."},
                 tracker.req_seen[REQ_REGISTER], tracker.req_seen[REQ_ENQUEUE],
                 tracker.req_seen[REQ_DEQUEUE], tracker.req_seen[REQ_PICK],
                 tracker.req_seen[REQ_CHECK],
                 tracker.req_seen[REQ_SPARE_LO] + tracker.req_seen[REQ_SPARE_MID] +
                 tracker.req_seen[REQ_SPARE_HI]);
        $display({"Responses: %0d ok, %0d unknown id, %0d table full, %0d queue empty, ",
                  "%0d reschedules; %0d mismatches."},
                 tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_UNKNOWN],
                 tracker.status_seen[STATUS_FULL], tracker.status_seen[STATUS_EMPTY],
                 tracker.resched_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.due_responses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
